// ===== rtl/fm_wavetable_sound_voice_core_defines.svh =====
// Assertion macros for the wavetable voice core.
// Used by files that carry concurrent checks; expects clk and arst_n in scope.
`ifndef FM_WAVETABLE_SOUND_VOICE_CORE_DEFINES_SVH
`define FM_WAVETABLE_SOUND_VOICE_CORE_DEFINES_SVH

// same-cycle implication
`define FMWV_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FMWV_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fmwv_pkg.sv =====
// Shared types and constants for the wavetable voice core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fmwv_pkg;

	localparam int WAVE_ENTRIES = 64;
	localparam int WAVE_AW = $clog2(WAVE_ENTRIES);

	localparam logic [19:0] PHASE_STEP_RST = 20'd55930;
	localparam logic [19:0] ENV_STEP_RST = 20'd27962;
	localparam logic [20:0] ENV_PERIOD_RST = 21'(8'hE8) << 12;

	localparam logic CFG_PHASE_STEP = 1'b0;
	localparam logic CFG_ENV_STEP = 1'b1;

	localparam logic [6:0] ADDR_CAR_ENV = 7'd64;
	localparam logic [6:0] ADDR_CAR_LO = 7'd66;
	localparam logic [6:0] ADDR_CAR_HI = 7'd67;
	localparam logic [6:0] ADDR_MOD_ENV = 7'd68;
	localparam logic [6:0] ADDR_MOD_BIAS = 7'd69;
	localparam logic [6:0] ADDR_MOD_LO = 7'd70;
	localparam logic [6:0] ADDR_MOD_HI = 7'd71;
	localparam logic [6:0] ADDR_MOD_APP = 7'd72;
	localparam logic [6:0] ADDR_MASTER = 7'd73;
	localparam logic [6:0] ADDR_PERIOD = 7'd74;

	localparam logic [2:0] APP_RESET_CODE = 3'd4;

	typedef struct packed {
		logic wr_env;
		logic sel;
		logic wr_period;
		logic add;
		logic iterate;
		logic [7:0] data;
	} env_ctl_t;

	typedef struct packed {
		logic [5:0] vol0;
		logic [5:0] vol1;
		logic pend;
		logic period_nz;
	} env_stat_t;

	function automatic logic [7:0] step_delta(input logic [2:0] code);
		logic [7:0] d;
		case (code)
			3'd1: d = 8'd2;
			3'd2: d = 8'd4;
			3'd3: d = 8'd8;
			3'd5: d = 8'd248;
			3'd6: d = 8'd252;
			3'd7: d = 8'd254;
			default: d = 8'd0;
		endcase
		return d;
	endfunction

	function automatic logic [4:0] level_scale(input logic [1:0] lvl);
		logic [4:0] s;
		case (lvl)
			2'd0: s = 5'd30;
			2'd1: s = 5'd20;
			2'd2: s = 5'd15;
			default: s = 5'd12;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/fm_wavetable_sound_voice_core.sv =====
// Sequence: a write completes in ST_IDLE (a modulator table append also passes ST_APP);
// a sample tick runs ST_ENV, ST_LOOP once per envelope step when the envelope runs, then
// ST_RD, ST_M1, ST_M2, ST_M3 and ST_FIN, which loads the result once the output is free.
// One transfer is in flight; the next is taken in the cycle after the result is loaded.
// Reset: asynchronous, active low; wave memories read their reset contents through
// per-entry valid flags, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "fm_wavetable_sound_voice_core_defines.svh"
module fm_wavetable_sound_voice_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [19:0] cfg_wdata,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic req_type,
	input wire logic [6:0] address_offset,
	input wire logic [7:0] write_data,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [13:0] sample
);
	localparam int AW = fmwv_pkg::WAVE_AW;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_APP  = 9'b000000010,
		ST_ENV  = 9'b000000100,
		ST_LOOP = 9'b000001000,
		ST_RD   = 9'b000010000,
		ST_M1   = 9'b000100000,
		ST_M2   = 9'b001000000,
		ST_M3   = 9'b010000000,
		ST_FIN  = 9'b100000000
	} state_t;

	state_t state_q;
	logic [19:0] phase_step_q, env_step_q;
	logic [31:0] car_phase_q, mod_phase_q;
	logic [11:0] car_pitch_q, mod_pitch_q;
	logic [7:0] mod_bias_q, base_q, delta_q;
	logic [AW-1:0] ptr_q;
	logic halt_car_q, halt_mod_q, halt_env_q, mute_q;
	logic [1:0] level_q;
	logic [fmwv_pkg::WAVE_ENTRIES-1:0] car_vld_q, mod_vld_q;
	logic out_valid_q;
	logic signed [13:0] sample_q;

	logic car_vld_s1, car_hi_s1, mod_vld_s1;
	logic [11:0] m_s1;
	logic signed [10:0] acc_s1;
	logic [31:0] mod_inc_s1;
	logic [13:0] cpm_s2;
	logic signed [15:0] scaled_s2;
	logic [31:0] car_inc_s3;
	logic [12:0] q_s3;
	logic neg_s3;

	logic accept, wr_req, load_out;
	fmwv_pkg::env_ctl_t env_ctl;
	fmwv_pkg::env_stat_t env_stat;

	logic car_we, mod_we;
	logic [AW-1:0] car_waddr, mod_waddr, car_raddr, mod_raddr;
	logic [5:0] car_wdata, car_rdata;
	logic [7:0] mod_wdata, mod_rdata;
	logic [7:0] base_start, base_one, base_two, app_delta;

	logic [7:0] mod_out, mod_sum;
	logic signed [5:0] car_out;
	logic signed [8:0] off;
	logic signed [15:0] vprod;
	logic [5:0] vol0c;
	logic signed [12:0] aprod;
	logic [13:0] inc_opnd;
	logic [33:0] inc_prod;
	logic [23:0] cpm_full;
	logic signed [21:0] sc_full;
	logic [14:0] mag;
	logic [31:0] q_full;
	logic signed [13:0] qs;
	logic signed [14:0] triple;

	assign accept = in_valid && !in_stall;
	assign wr_req = accept && !req_type;
	assign in_stall = state_q != ST_IDLE;
	assign load_out = state_q == ST_FIN && (!out_valid_q || !out_stall);

	// modulator table append
	assign base_start = (write_data[2:0] == fmwv_pkg::APP_RESET_CODE) ? 8'd0 : base_q;
	assign app_delta = fmwv_pkg::step_delta(write_data[2:0]);
	assign base_one = base_start + app_delta;
	assign base_two = base_q + delta_q;

	assign car_we = wr_req && address_offset < 7'(fmwv_pkg::WAVE_ENTRIES);
	assign car_waddr = address_offset[AW-1:0];
	assign car_wdata = {~write_data[5], write_data[4:0]};
	assign car_raddr = car_phase_q[31 -: AW];

	assign mod_we = (wr_req && address_offset == fmwv_pkg::ADDR_MOD_APP && halt_mod_q)
		|| state_q == ST_APP;
	assign mod_waddr = (state_q == ST_APP) ? ptr_q + AW'(1) : ptr_q;
	assign mod_wdata = ((state_q == ST_APP) ? base_two : base_one) + 8'd64;
	assign mod_raddr = mod_phase_q[31 -: AW];

	always_comb begin
		env_ctl = '0;
		env_ctl.data = write_data;
		env_ctl.sel = address_offset[2];
		env_ctl.wr_env = wr_req && (address_offset == fmwv_pkg::ADDR_CAR_ENV
			|| address_offset == fmwv_pkg::ADDR_MOD_ENV);
		env_ctl.wr_period = wr_req && address_offset == fmwv_pkg::ADDR_PERIOD;
		env_ctl.add = state_q == ST_ENV && !halt_env_q;
		env_ctl.iterate = state_q == ST_LOOP && env_stat.pend;
	end

	fmwv_ram #(.WIDTH(6), .DEPTH(fmwv_pkg::WAVE_ENTRIES)) u_car_ram (
		.clk(clk), .we(car_we), .waddr(car_waddr), .wdata(car_wdata),
		.raddr(car_raddr), .rdata(car_rdata)
	);

	fmwv_ram #(.WIDTH(8), .DEPTH(fmwv_pkg::WAVE_ENTRIES)) u_mod_ram (
		.clk(clk), .we(mod_we), .waddr(mod_waddr), .wdata(mod_wdata),
		.raddr(mod_raddr), .rdata(mod_rdata)
	);

	fmwv_env u_env (
		.clk(clk), .arst_n(arst_n), .ctl(env_ctl), .env_step(env_step_q), .stat(env_stat)
	);

	// operator outputs and arithmetic
	always_comb begin
		mod_out = (halt_mod_q || !mod_vld_s1) ? 8'd0 : mod_rdata;
		if (halt_car_q || mute_q) car_out = '0;
		else if (car_vld_s1) car_out = car_rdata;
		else car_out = car_hi_s1 ? 6'sh20 : 6'sh1F;
		mod_sum = mod_out + mod_bias_q;
		off = $signed({1'b0, mod_sum}) - 9'sd64;
		vprod = $signed({1'b0, env_stat.vol1}) * off;
		vol0c = (env_stat.vol0 > 6'd32) ? 6'd32 : env_stat.vol0;
		aprod = car_out * $signed({1'b0, vol0c});
		cpm_full = car_pitch_q * m_s1;
		sc_full = acc_s1 * $signed({1'b0, fmwv_pkg::level_scale(level_q)});
		inc_opnd = halt_mod_q ? {2'b00, car_pitch_q} : cpm_s2;
		inc_prod = inc_opnd * phase_step_q;
		mag = scaled_s2[15] ? 15'(-scaled_s2) : scaled_s2[14:0];
		q_full = {2'b00, mag} * 17'd52429;
		qs = neg_s3 ? -$signed({1'b0, q_s3}) : $signed({1'b0, q_s3});
		triple = 15'(qs) + (15'(qs) <<< 1);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD) begin
			car_vld_s1 <= car_vld_q[car_raddr];
			car_hi_s1 <= car_raddr[AW-1];
			mod_vld_s1 <= mod_vld_q[mod_raddr];
		end
		if (state_q == ST_M1) begin
			m_s1 <= 12'(16'sd1024 + vprod);
			acc_s1 <= aprod[10:0];
			mod_inc_s1 <= 32'(mod_pitch_q * phase_step_q);
		end
		if (state_q == ST_M2) begin
			cpm_s2 <= cpm_full[23:10];
			scaled_s2 <= sc_full[15:0];
		end
		if (state_q == ST_M3) begin
			car_inc_s3 <= inc_prod[31:0];
			q_s3 <= q_full[31:19];
			neg_s3 <= scaled_s2[15];
		end
		if (load_out) begin
			sample_q <= (car_pitch_q != '0) ? triple[14:1] : 14'sd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_step_q <= fmwv_pkg::PHASE_STEP_RST;
			env_step_q <= fmwv_pkg::ENV_STEP_RST;
			car_phase_q <= '0;
			mod_phase_q <= '0;
			car_pitch_q <= '0;
			mod_pitch_q <= '0;
			mod_bias_q <= '0;
			base_q <= '0;
			delta_q <= '0;
			ptr_q <= '0;
			halt_car_q <= 1'b0;
			halt_mod_q <= 1'b0;
			halt_env_q <= 1'b1;
			mute_q <= 1'b0;
			level_q <= '0;
			car_vld_q <= '0;
			mod_vld_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == fmwv_pkg::CFG_PHASE_STEP) phase_step_q <= cfg_wdata;
				else env_step_q <= cfg_wdata;
			end
			if (car_we) car_vld_q[car_waddr] <= 1'b1;
			if (mod_we) mod_vld_q[mod_waddr] <= 1'b1;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (load_out) out_valid_q <= 1'b1;

			case (state_q)
				ST_IDLE: begin
					if (accept && req_type) begin
						state_q <= ST_ENV;
					end else if (wr_req) begin
						case (address_offset)
							fmwv_pkg::ADDR_CAR_LO: car_pitch_q[7:0] <= write_data;
							fmwv_pkg::ADDR_CAR_HI: begin
								car_pitch_q[11:8] <= write_data[3:0];
								halt_car_q <= write_data[7];
								halt_env_q <= write_data[6];
								if (write_data[7]) car_phase_q <= '0;
							end
							fmwv_pkg::ADDR_MOD_BIAS: mod_bias_q <= write_data;
							fmwv_pkg::ADDR_MOD_LO: mod_pitch_q[7:0] <= write_data;
							fmwv_pkg::ADDR_MOD_HI: begin
								mod_pitch_q[11:8] <= write_data[3:0];
								halt_mod_q <= write_data[7];
								if (write_data[7]) mod_phase_q <= '0;
							end
							fmwv_pkg::ADDR_MOD_APP: begin
								if (halt_mod_q) begin
									base_q <= base_one;
									delta_q <= app_delta;
									state_q <= ST_APP;
								end
							end
							fmwv_pkg::ADDR_MASTER: begin
								level_q <= write_data[1:0];
								mute_q <= write_data[7];
							end
							default: ;
						endcase
					end
				end
				ST_APP: begin
					base_q <= base_two;
					ptr_q <= ptr_q + AW'(2);
					state_q <= ST_IDLE;
				end
				ST_ENV: begin
					state_q <= (!halt_env_q && env_stat.period_nz) ? ST_LOOP : ST_RD;
				end
				ST_LOOP: begin
					if (!env_stat.pend) state_q <= ST_RD;
				end
				ST_RD: state_q <= ST_M1;
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_M3;
				ST_M3: state_q <= ST_FIN;
				ST_FIN: begin
					if (load_out) begin
						mod_phase_q <= mod_phase_q + mod_inc_s1;
						car_phase_q <= car_phase_q + car_inc_s3;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign sample = sample_q;

	`FMWV_ASSERT_IMP(a_state_onehot, 1'b1, $onehot(state_q), "state not one-hot")
	`FMWV_ASSERT_NXT(a_loop_exit, state_q == ST_LOOP && !env_stat.pend, state_q == ST_RD,
		"envelope loop did not exit")
	`FMWV_ASSERT_NXT(a_out_load, load_out, out_valid_q, "result not presented")
	`FMWV_ASSERT_NXT(a_zero_pitch, load_out && car_pitch_q == '0, sample_q == 14'sd0,
		"nonzero sample with zero pitch")
endmodule
`default_nettype wire

// ===== rtl/fmwv_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module fmwv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/fmwv_env.sv =====
// Envelope generators and their shared fractional accumulator.
// Depends on fmwv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fmwv_env (
	input wire logic clk,
	input wire logic arst_n,
	input wire fmwv_pkg::env_ctl_t ctl,
	input wire logic [19:0] env_step,
	output fmwv_pkg::env_stat_t stat
);
	logic [5:0] vol_q [2];
	logic [5:0] speed_q [2];
	logic [6:0] cnt_q [2];
	logic [1:0] mode_q [2];
	logic [20:0] accum_q;
	logic [20:0] period_q;

	logic [5:0] vol_n [2];
	logic [6:0] cnt_n [2];
	logic [6:0] cnt_inc;

	always_comb begin
		for (int e = 0; e < 2; e++) begin
			vol_n[e] = vol_q[e];
			cnt_n[e] = cnt_q[e];
			cnt_inc = cnt_q[e] + 7'd1;
			if (!mode_q[e][1] && speed_q[e] != 6'd0) begin
				if (cnt_inc <= {1'b0, speed_q[e]}) begin
					cnt_n[e] = cnt_inc;
				end else begin
					cnt_n[e] = 7'd0;
					if (mode_q[e][0]) begin
						if (vol_q[e] < 6'h1F) vol_n[e] = vol_q[e] + 6'd1;
					end else begin
						if (vol_q[e] != 6'd0) vol_n[e] = vol_q[e] - 6'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < 2; e++) begin
				vol_q[e] <= '0;
				speed_q[e] <= '0;
				cnt_q[e] <= '0;
				mode_q[e] <= '0;
			end
			accum_q <= '0;
			period_q <= fmwv_pkg::ENV_PERIOD_RST;
		end else begin
			if (ctl.wr_env) begin
				mode_q[ctl.sel] <= ctl.data[7:6];
				if (ctl.data[7]) vol_q[ctl.sel] <= ctl.data[5:0];
				else speed_q[ctl.sel] <= ctl.data[5:0];
			end
			if (ctl.wr_period) begin
				period_q <= {({1'b0, ctl.data} + 9'd1), 12'd0};
			end
			if (ctl.add && period_q != '0) begin
				accum_q <= accum_q + {1'b0, env_step};
			end
			if (ctl.iterate) begin
				accum_q <= accum_q - period_q;
				for (int e = 0; e < 2; e++) begin
					vol_q[e] <= vol_n[e];
					cnt_q[e] <= cnt_n[e];
				end
			end
		end
	end

	assign stat.vol0 = vol_q[0];
	assign stat.vol1 = vol_q[1];
	assign stat.pend = accum_q >= period_q;
	assign stat.period_nz = period_q != '0;
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Testbench for fm_wavetable_sound_voice_core: random writes and sample ticks.
// A built-in voice predictor checks every sample. Depends on fmwv_pkg and the core RTL.
`timescale 1ns / 1ps
module tb;

	typedef struct packed {
		logic       kind;
		logic [6:0] addr;
		logic [7:0] data;
	} voice_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [19:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = 1'b0;
	logic [6:0] address_offset = '0;
	logic [7:0] write_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [13:0] sample;

	fm_wavetable_sound_voice_core dut (.*);

	initial forever #5 clk = ~clk;

	voice_req_t pending_reqs[$];
	logic [13:0] expected_samples[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int errors = 0;

	// predictor state
	logic [19:0] p_phase_step, p_env_step;
	logic [5:0] p_car_wave[64];
	logic [7:0] p_mod_wave[64];
	logic [31:0] p_car_phase, p_mod_phase, p_env_accum, p_env_period;
	logic [11:0] p_car_pitch, p_mod_pitch;
	logic [5:0] p_vol[2], p_speed[2];
	logic [6:0] p_count[2];
	logic [1:0] p_mode[2];
	logic [7:0] p_bias, p_base;
	logic [5:0] p_ptr;
	logic [3:0] p_halt;
	logic [1:0] p_level;

	function automatic logic [7:0] delta_of(input logic [2:0] c);
		case (c)
			3'd1: return 8'd2;
			3'd2: return 8'd4;
			3'd3: return 8'd8;
			3'd5: return 8'd248;
			3'd6: return 8'd252;
			3'd7: return 8'd254;
			default: return 8'd0;
		endcase
	endfunction

	task automatic voice_reset();
		p_phase_step = fmwv_pkg::PHASE_STEP_RST;
		p_env_step = fmwv_pkg::ENV_STEP_RST;
		for (int i = 0; i < 64; i++) begin
			p_car_wave[i] = (i < 32) ? 6'd31 : 6'h20;
			p_mod_wave[i] = 8'd0;
		end
		p_car_phase = 0; p_mod_phase = 0; p_car_pitch = 0; p_mod_pitch = 0;
		for (int e = 0; e < 2; e++) begin
			p_vol[e] = 0; p_speed[e] = 0; p_count[e] = 0; p_mode[e] = 0;
		end
		p_bias = 0; p_base = 0; p_ptr = 0; p_halt = 4'b0100;
		p_env_accum = 0; p_env_period = 32'hE8 << 12; p_level = 0;
	endtask

	function automatic void env_advance(input int e);
		if (p_mode[e][1] || p_speed[e] == 0) return;
		p_count[e] = p_count[e] + 7'd1;
		if (p_count[e] <= {1'b0, p_speed[e]}) return;
		p_count[e] = 0;
		if (p_mode[e][0]) begin
			if (p_vol[e] < 6'h1F) p_vol[e]++;
		end else if (p_vol[e] > 0) p_vol[e]--;
	endfunction

	task automatic voice_write(input logic [6:0] a, input logic [7:0] v);
		int e;
		logic [7:0] d;
		e = a[2];
		if (a < 64) begin
			p_car_wave[a[5:0]] = v[5:0] - 6'h20;
			return;
		end
		case (a)
			fmwv_pkg::ADDR_CAR_ENV, fmwv_pkg::ADDR_MOD_ENV: begin
				p_mode[e] = v[7:6];
				if (v[7]) p_vol[e] = v[5:0];
				else p_speed[e] = v[5:0];
			end
			fmwv_pkg::ADDR_MOD_BIAS: p_bias = v;
			fmwv_pkg::ADDR_CAR_LO: p_car_pitch[7:0] = v;
			fmwv_pkg::ADDR_MOD_LO: p_mod_pitch[7:0] = v;
			fmwv_pkg::ADDR_CAR_HI: begin
				p_car_pitch[11:8] = v[3:0];
				p_halt[0] = v[7];
				p_halt[2] = v[6];
				if (v[7]) p_car_phase = 0;
			end
			fmwv_pkg::ADDR_MOD_HI: begin
				p_mod_pitch[11:8] = v[3:0];
				p_halt[1] = v[7];
				if (v[7]) p_mod_phase = 0;
			end
			fmwv_pkg::ADDR_MOD_APP: if (p_halt[1]) begin
				if (v[2:0] == fmwv_pkg::APP_RESET_CODE) p_base = 0;
				d = delta_of(v[2:0]);
				p_base = p_base + d;
				p_mod_wave[p_ptr] = p_base + 8'd64;
				p_base = p_base + d;
				p_mod_wave[p_ptr + 6'd1] = p_base + 8'd64;
				p_ptr = p_ptr + 6'd2;
			end
			fmwv_pkg::ADDR_MASTER: begin
				p_level = v[1:0];
				p_halt[3] = v[7];
			end
			fmwv_pkg::ADDR_PERIOD: p_env_period = ({24'd0, v} + 32'd1) << 12;
			default: ;
		endcase
	endtask

	function automatic logic [13:0] voice_tick();
		int mod_out, car_out, vol, acc, off, sc;
		logic [31:0] car_inc, mod_inc, m;
		if (!p_halt[2] && p_env_period != 0) begin
			p_env_accum += p_env_step;
			while (p_env_accum >= p_env_period) begin
				p_env_accum -= p_env_period;
				env_advance(1);
				env_advance(0);
			end
		end
		mod_out = p_halt[1] ? 0 : p_mod_wave[p_mod_phase[31:26]];
		car_out = (p_halt[0] || p_halt[3]) ? 0 : $signed(p_car_wave[p_car_phase[31:26]]);
		mod_inc = p_mod_pitch * p_phase_step;
		if (p_halt[1]) car_inc = p_car_pitch * p_phase_step;
		else begin
			off = ((mod_out + p_bias) & 255) - 64;
			m = (1024 + p_vol[1] * off) & 32'hFFF;
			car_inc = ((p_car_pitch * m) >> 10) * p_phase_step;
		end
		vol = (p_vol[0] > 6'h20) ? 32 : p_vol[0];
		acc = car_out * vol;
		p_mod_phase += mod_inc;
		p_car_phase += car_inc;
		case (p_level)
			2'd0: sc = 30;
			2'd1: sc = 20;
			2'd2: sc = 15;
			default: sc = 12;
		endcase
		acc = (acc * sc) / 10;
		acc = acc * 3;
		acc = (acc >= 0) ? (acc >> 1) : -((-acc + 1) >> 1);
		return (p_car_pitch != 0) ? acc[13:0] : 14'd0;
	endfunction

	// driver
	logic in_took;
	always @(posedge clk) in_took <= arst_n && in_valid && !in_stall;

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_took) begin
				if (in_took) begin
					if (req_type) expected_samples.push_back(voice_tick());
					else voice_write(address_offset, write_data);
				end
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					voice_req_t r;
					r = pending_reqs.pop_front();
					in_valid <= 1'b1;
					req_type <= r.kind;
					address_offset <= r.addr;
					write_data <= r.data;
				end else in_valid <= 1'b0;
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// the driver books a transfer at the falling edge; the monitor checks after that
	logic got_valid;
	logic [13:0] got_sample;
	always @(posedge clk) begin
		got_valid <= arst_n && out_valid && !out_stall;
		got_sample <= sample;
	end
	always @(negedge clk) begin
		#1;
		if (got_valid) begin
			if (expected_samples.size() == 0) begin
				$error("sample with no transfer pending: actual %0d", $signed(got_sample));
				errors++;
			end else begin
				logic [13:0] exp_s;
				exp_s = expected_samples.pop_front();
				if (exp_s !== got_sample) begin
					$error("sample: expected %0d actual %0d", $signed(exp_s),
						$signed(got_sample));
					errors++;
				end
			end
		end
	end

	function automatic voice_req_t rand_req();
		voice_req_t r;
		int k;
		k = $urandom_range(99);
		r.data = 8'($urandom);
		if (k < 45) begin
			r.kind = 1'b1; r.addr = 7'($urandom); r.data = 8'($urandom);
		end else if (k < 60) begin
			r.kind = 1'b0; r.addr = 7'($urandom_range(63));
		end else if (k < 97) begin
			r.kind = 1'b0; r.addr = 7'($urandom_range(64, 74));
			if (r.addr == fmwv_pkg::ADDR_PERIOD && $urandom_range(3) != 0)
				r.data = 8'($urandom_range(7));
		end else begin
			r.kind = 1'b0; r.addr = 7'($urandom_range(75, 127));
		end
		return r;
	endfunction

	task automatic add_req(input logic k, input logic [6:0] a, input logic [7:0] d);
		pending_reqs.push_back('{k, a, d});
	endtask

	task automatic drain();
		wait (pending_reqs.size() == 0);
		@(negedge clk);
		while (in_valid || expected_samples.size() != 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	task automatic set_cfg(input logic idx, input logic [19:0] val);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == fmwv_pkg::CFG_PHASE_STEP) p_phase_step = val;
		else p_env_step = val;
	endtask

	initial begin
		voice_reset();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// directed
		add_req(1'b1, 7'd0, 8'd0);
		add_req(1'b0, fmwv_pkg::ADDR_CAR_LO, 8'hFF);
		add_req(1'b0, fmwv_pkg::ADDR_CAR_HI, 8'h0F);
		add_req(1'b0, fmwv_pkg::ADDR_CAR_ENV, 8'hBF);
		add_req(1'b1, 7'd0, 8'd0);
		add_req(1'b0, 7'd0, 8'h00);
		add_req(1'b0, 7'd63, 8'hFF);
		add_req(1'b0, fmwv_pkg::ADDR_MASTER, 8'h03);
		add_req(1'b1, 7'd0, 8'd0);
		add_req(1'b0, fmwv_pkg::ADDR_MASTER, 8'h82);
		add_req(1'b1, 7'd0, 8'd0);
		add_req(1'b0, fmwv_pkg::ADDR_MASTER, 8'h01);
		add_req(1'b0, fmwv_pkg::ADDR_MOD_HI, 8'h80);
		for (int i = 0; i < 8; i++) add_req(1'b0, fmwv_pkg::ADDR_MOD_APP, 8'(i));
		add_req(1'b0, fmwv_pkg::ADDR_MOD_ENV, 8'h9F);
		add_req(1'b0, fmwv_pkg::ADDR_MOD_BIAS, 8'hFF);
		add_req(1'b0, fmwv_pkg::ADDR_MOD_LO, 8'h55);
		add_req(1'b0, fmwv_pkg::ADDR_MOD_HI, 8'h0F);
		add_req(1'b0, fmwv_pkg::ADDR_MOD_APP, 8'h01);
		add_req(1'b0, fmwv_pkg::ADDR_CAR_ENV, 8'h01);
		add_req(1'b0, fmwv_pkg::ADDR_PERIOD, 8'h00);
		add_req(1'b0, 7'd65, 8'hFF);
		add_req(1'b0, 7'd127, 8'hFF);
		add_req(1'b1, 7'd0, 8'd0);
		add_req(1'b1, 7'd0, 8'd0);
		drain();
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin set_cfg(fmwv_pkg::CFG_PHASE_STEP, 20'hFFFFF);
					set_cfg(fmwv_pkg::CFG_ENV_STEP, 20'd0);
					send_idle_pct = 19; recv_idle_pct = 46; end
				1: begin set_cfg(fmwv_pkg::CFG_PHASE_STEP, 20'd0);
					set_cfg(fmwv_pkg::CFG_ENV_STEP, 20'd40000);
					send_idle_pct = 46; recv_idle_pct = 19; end
				default: begin set_cfg(fmwv_pkg::CFG_PHASE_STEP, 20'($urandom));
					set_cfg(fmwv_pkg::CFG_ENV_STEP, 20'($urandom_range(20000, 90000)));
					send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			for (int i = 0; i < 250; i++) pending_reqs.push_back(rand_req());
			drain();
		end
		if (errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end
endmodule

// ===== fm_wavetable_sound_voice_core.f =====
+incdir+rtl
rtl/fmwv_pkg.sv
rtl/fmwv_ram.sv
rtl/fmwv_env.sv
rtl/fm_wavetable_sound_voice_core.sv
test/tb.sv
